/* hdl/thermal_lifecycle_and_updraft_defines.svh */
// Assertion macros shared by the thermal updraft RTL.
`ifndef THERMAL_LIFECYCLE_AND_UPDRAFT_DEFINES_SVH
`define THERMAL_LIFECYCLE_AND_UPDRAFT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tlu_pkg.sv */
// Types, codes and constants shared by the thermal updraft modules.
package tlu_pkg;

    // Field and datapath widths.
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int COORD_W    = 24;
    localparam int VAL_W      = 16;
    localparam int RSQ_W      = 32;
    localparam int DIFF_W     = 25;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = 50;
    localparam int QUOT_W     = 16;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_NUM_W  = DIV_DEN_W + QUOT_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx REG_BASE_X        = 3'd0;
    localparam t_cfg_idx REG_BASE_Y        = 3'd1;
    localparam t_cfg_idx REG_BASE_Z        = 3'd2;
    localparam t_cfg_idx REG_CYL_HEIGHT    = 3'd3;
    localparam t_cfg_idx REG_FULL_RADIUS   = 3'd4;
    localparam t_cfg_idx REG_PEAK_STRENGTH = 3'd5;
    localparam t_cfg_idx REG_RAMP_RATE     = 3'd6;
    localparam t_cfg_idx REG_SHRINK_RATE   = 3'd7;

    // Register values after reset.
    localparam logic [VAL_W-1:0] RST_CYL_HEIGHT    = 16'd2560;
    localparam logic [VAL_W-1:0] RST_FULL_RADIUS   = 16'd768;
    localparam logic [VAL_W-1:0] RST_PEAK_STRENGTH = 16'd256;
    localparam logic [VAL_W-1:0] RST_RAMP_RATE     = 16'd26;
    localparam logic [VAL_W-1:0] RST_SHRINK_RATE   = 16'd256;

    // Item commands.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Life cycle phases.
    typedef enum logic [1:0] {
        PH_GROWING   = 2'd0,
        PH_ON        = 2'd1,
        PH_SHRINKING = 2'd2,
        PH_OFF       = 2'd3
    } t_phase;

    typedef struct packed {
        logic                      cmd;
        logic [15:0]               step_time;
        logic [15:0]               random_draw;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] velocity_z;
        logic [VAL_W-1:0] strength_now;
        logic [RSQ_W-1:0] radius_squared;
        logic [1:0]       phase;
        logic             finished;
    } t_out_item;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_INC,
        OP_MUL_SHR,
        OP_LIFE,
        OP_MUL_FS,
        OP_RAD_PICK,
        OP_RAD_TAKE,
        OP_MUL_RR,
        OP_SAVE_RSQ,
        OP_DIFF,
        OP_MUL_DX,
        OP_MUL_DY,
        OP_SUM,
        OP_MUL_VS,
        OP_DIV_VEL,
        OP_VEL_TAKE,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic finished;
        logic rad_zero;
        logic rad_sat;
        logic in_cyl;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/tlu_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
interface tlu_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/tlu_div.sv */
// Restoring serial divider producing a 16-bit quotient, one bit per cycle.
`include "thermal_lifecycle_and_updraft_defines.svh"

module tlu_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tlu_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [tlu_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [tlu_pkg::QUOT_W-1:0]     o_quot
);
    import tlu_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [QUOT_W-1:0]    r_low;
    logic [DIV_DEN_W-1:0] r_den;
    logic [QUOT_W-1:0]    r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // One trial subtraction per cycle.
    assign w_trial = {r_rem, r_low[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // Sequencing: busy for exactly one step per quotient bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The upper numerator bits start as the partial remainder; the caller
    // guarantees they are below the divisor, so 16 quotient bits suffice.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[DIV_NUM_W-1:QUOT_W];
            r_low  <= i_num[QUOT_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `TLU_ASSERT_SAME(a_div_start_idle, i_start, !r_busy, "divider restarted while busy")
    `TLU_ASSERT_SAME(a_div_range, i_start, i_num[DIV_NUM_W-1:QUOT_W] < i_den,
        "quotient would not fit in 16 bits")

endmodule

/* hdl/tlu_ctrl.sv */
// Controller state machine sequencing ticks and queries through the datapath.
`include "thermal_lifecycle_and_updraft_defines.svh"

module tlu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tlu_pkg::t_dp_status i_status,
    output tlu_pkg::t_dp_cmd    o_cmd
);
    import tlu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL_SHR,
        S_LIFE,
        S_MUL_FS,
        S_RAD_PICK,
        S_DIV_R,
        S_MUL_RR,
        S_SAVE_RSQ,
        S_MUL_DX,
        S_MUL_DY,
        S_SUM,
        S_CHECK,
        S_DIV_V_START,
        S_DIV_V,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    t_dp_op w_op;

    // Next state and the datapath operation for this cycle.
    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (r_in_ready && i_in_valid) begin
                    w_op    = OP_LOAD;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.is_query) begin
                    w_op    = OP_DIFF;
                    n_state = S_MUL_DX;
                end else begin
                    w_op    = OP_MUL_INC;
                    n_state = S_MUL_SHR;
                end
            end
            S_MUL_SHR: begin
                w_op    = OP_MUL_SHR;
                n_state = S_LIFE;
            end
            S_LIFE: begin
                w_op    = OP_LIFE;
                n_state = S_MUL_FS;
            end
            S_MUL_FS: begin
                // A finishing tick leaves the radius as it was.
                if (i_status.finished) begin
                    n_state = S_OUT;
                end else begin
                    w_op    = OP_MUL_FS;
                    n_state = S_RAD_PICK;
                end
            end
            S_RAD_PICK: begin
                w_op = OP_RAD_PICK;
                if (i_status.rad_zero || i_status.rad_sat) begin
                    n_state = S_MUL_RR;
                end else begin
                    n_state = S_DIV_R;
                end
            end
            S_DIV_R: begin
                if (i_status.div_done) begin
                    w_op    = OP_RAD_TAKE;
                    n_state = S_MUL_RR;
                end
            end
            S_MUL_RR: begin
                w_op    = OP_MUL_RR;
                n_state = S_SAVE_RSQ;
            end
            S_SAVE_RSQ: begin
                w_op    = OP_SAVE_RSQ;
                n_state = S_OUT;
            end
            S_MUL_DX: begin
                w_op    = OP_MUL_DX;
                n_state = S_MUL_DY;
            end
            S_MUL_DY: begin
                w_op    = OP_MUL_DY;
                n_state = S_SUM;
            end
            S_SUM: begin
                w_op    = OP_SUM;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.in_cyl) begin
                    w_op    = OP_MUL_VS;
                    n_state = S_DIV_V_START;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_V_START: begin
                w_op    = OP_DIV_VEL;
                n_state = S_DIV_V;
            end
            S_DIV_V: begin
                if (i_status.div_done) begin
                    w_op    = OP_VEL_TAKE;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    w_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered input ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd.op   = w_op;

    `TLU_ASSERT_NEXT(a_accept_closes, i_in_valid && r_in_ready, !r_in_ready,
        "second transaction accepted while an item is in progress")

endmodule

/* hdl/tlu_datapath.sv */
// Datapath: configuration and life cycle registers, shared multiplier,
// serial divider and the output register.
`include "thermal_lifecycle_and_updraft_defines.svh"

module tlu_datapath #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  tlu_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [tlu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  tlu_pkg::t_in_item                i_item,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output tlu_pkg::t_out_item               o_out,
    input  tlu_pkg::t_dp_cmd                 i_cmd,
    output tlu_pkg::t_dp_status              o_status
);
    import tlu_pkg::*;

    localparam int DRAW_W = 16 + FRAC_BITS;
    localparam int CMP_W  = 33;
    localparam int ZEXT_W = COORD_W + 2;

    // Configuration registers.
    logic signed [COORD_W-1:0] r_base_x;
    logic signed [COORD_W-1:0] r_base_y;
    logic signed [COORD_W-1:0] r_base_z;
    logic [VAL_W-1:0]          r_cyl_height;
    logic [VAL_W-1:0]          r_full_radius;
    logic [VAL_W-1:0]          r_peak;
    logic [VAL_W-1:0]          r_ramp;
    logic [VAL_W-1:0]          r_shrink;
    logic [VAL_W-1:0]          n_peak;
    logic [VAL_W-1:0]          n_ramp;

    // Life cycle state.
    t_phase                    r_phase;
    logic [VAL_W-1:0]          r_strength;
    logic [RSQ_W-1:0]          r_rsq;
    t_phase                    n_phase;
    logic [VAL_W-1:0]          n_strength;
    logic                      n_life_done;

    // Working registers for the current item.
    t_in_item                  r_item;
    logic [VAL_W-1:0]          r_inc;
    logic [PROD_W-1:0]         r_prod;
    logic [DIFF_W-1:0]         r_dx;
    logic [DIFF_W-1:0]         r_dy;
    logic                      r_zin;
    logic [PROD_W-1:0]         r_acc;
    logic [VAL_W-1:0]          r_r;
    logic [VAL_W-1:0]          r_vel;
    logic                      r_finished;
    t_out_item                 r_out;
    logic                      r_out_valid;

    // Combinational helpers.
    logic [VAL_W:0]            w_grow_sum;
    logic [DRAW_W-1:0]         w_draw_sh;
    logic [CMP_W-1:0]          w_draw_cmp;
    logic [CMP_W-1:0]          w_shr_cmp;
    logic                      w_rad_zero;
    logic                      w_rad_sat;
    logic [DIFF_W-1:0]         w_dx;
    logic [DIFF_W-1:0]         w_dy;
    logic [DIFF_W-1:0]         w_dx_mag;
    logic [DIFF_W-1:0]         w_dy_mag;
    logic signed [ZEXT_W-1:0]  w_qz_ext;
    logic signed [ZEXT_W-1:0]  w_bz_ext;
    logic signed [ZEXT_W-1:0]  w_z_top;
    logic                      w_zin;
    logic [MUL_A_W-1:0]        w_mul_a;
    logic [MUL_B_W-1:0]        w_mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] w_mul_p;
    logic                      w_mul_en;
    logic                      w_div_start;
    logic [DIV_NUM_W-1:0]      w_div_num;
    logic [DIV_DEN_W-1:0]      w_div_den;
    logic                      w_div_done;
    logic [QUOT_W-1:0]         w_div_quot;

    // Peak and ramp as they stand after a configuration write this cycle.
    assign n_peak = (i_cfg_we && (i_cfg_idx == REG_PEAK_STRENGTH)) ?
                    i_cfg_data[VAL_W-1:0] : r_peak;
    assign n_ramp = (i_cfg_we && (i_cfg_idx == REG_RAMP_RATE)) ?
                    i_cfg_data[VAL_W-1:0] : r_ramp;

    // Shrink test: draw scaled to the rate format against shrink_rate * dt.
    assign w_draw_sh  = {r_item.random_draw, {FRAC_BITS{1'b0}}};
    assign w_draw_cmp = CMP_W'(w_draw_sh);
    assign w_shr_cmp  = CMP_W'(r_prod[RSQ_W-1:0]);
    assign w_grow_sum = {1'b0, r_strength} + {1'b0, r_inc};

    // Life cycle step for a tick.
    always_comb begin
        n_phase     = r_phase;
        n_strength  = r_strength;
        n_life_done = 1'b0;
        case (r_phase)
            PH_GROWING: begin
                if (w_grow_sum > {1'b0, r_peak}) begin
                    n_strength = r_peak;
                    n_phase    = PH_ON;
                end else begin
                    n_strength = w_grow_sum[VAL_W-1:0];
                end
            end
            PH_ON: begin
                if (w_draw_cmp < w_shr_cmp) begin
                    if (r_ramp == '0) begin
                        n_strength  = '0;
                        n_phase     = PH_OFF;
                        n_life_done = 1'b1;
                    end else begin
                        n_phase = PH_SHRINKING;
                    end
                end
            end
            PH_SHRINKING: begin
                if (r_inc >= r_strength) begin
                    n_strength  = '0;
                    n_phase     = PH_OFF;
                    n_life_done = 1'b1;
                end else begin
                    n_strength = r_strength - r_inc;
                end
            end
            PH_OFF: begin
                n_phase = PH_OFF;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Radius shortcuts: no peak gives radius zero, and a quotient that would
    // not fit in 16 bits saturates.
    assign w_rad_zero = (r_peak == '0);
    assign w_rad_sat  = (r_prod[RSQ_W-1:0] >= {r_peak, 16'b0});

    // Query geometry: horizontal offsets and the strict height window.
    assign w_dx     = {r_item.query_x[COORD_W-1], r_item.query_x}
                    - {r_base_x[COORD_W-1], r_base_x};
    assign w_dy     = {r_item.query_y[COORD_W-1], r_item.query_y}
                    - {r_base_y[COORD_W-1], r_base_y};
    assign w_dx_mag = w_dx[DIFF_W-1] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_mag = w_dy[DIFF_W-1] ? (~w_dy + 1'b1) : w_dy;
    assign w_qz_ext = {{2{r_item.query_z[COORD_W-1]}}, r_item.query_z};
    assign w_bz_ext = {{2{r_base_z[COORD_W-1]}}, r_base_z};
    assign w_z_top  = w_bz_ext + $signed({{(ZEXT_W-VAL_W){1'b0}}, r_cyl_height});
    assign w_zin    = (w_qz_ext > w_bz_ext) && (w_qz_ext < w_z_top);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (i_cmd.op)
            OP_MUL_INC: begin
                w_mul_a = MUL_A_W'(r_ramp);
                w_mul_b = MUL_B_W'(r_item.step_time);
            end
            OP_MUL_SHR: begin
                w_mul_a = MUL_A_W'(r_shrink);
                w_mul_b = MUL_B_W'(r_item.step_time);
            end
            OP_MUL_FS: begin
                w_mul_a = MUL_A_W'(r_full_radius);
                w_mul_b = MUL_B_W'(r_strength);
            end
            OP_MUL_RR: begin
                w_mul_a = MUL_A_W'(r_r);
                w_mul_b = MUL_B_W'(r_r);
            end
            OP_MUL_DX: begin
                w_mul_a = MUL_A_W'(r_dx);
                w_mul_b = r_dx;
            end
            OP_MUL_DY: begin
                w_mul_a = MUL_A_W'(r_dy);
                w_mul_b = r_dy;
            end
            OP_MUL_VS: begin
                w_mul_a = r_acc[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_strength);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Divider operands: radius from full_radius * strength over peak, or the
    // velocity from dist_sq * strength over radius squared.
    assign w_div_start = ((i_cmd.op == OP_RAD_PICK) && !w_rad_zero && !w_rad_sat)
                       || (i_cmd.op == OP_DIV_VEL);
    assign w_div_num   = (i_cmd.op == OP_DIV_VEL) ? r_prod[DIV_NUM_W-1:0]
                       : DIV_NUM_W'(r_prod[RSQ_W-1:0]);
    assign w_div_den   = (i_cmd.op == OP_DIV_VEL) ? r_rsq : DIV_DEN_W'(r_peak);

    tlu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Configuration, life cycle state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_base_z      <= '0;
            r_cyl_height  <= RST_CYL_HEIGHT;
            r_full_radius <= RST_FULL_RADIUS;
            r_peak        <= RST_PEAK_STRENGTH;
            r_ramp        <= RST_RAMP_RATE;
            r_shrink      <= RST_SHRINK_RATE;
            r_phase       <= PH_GROWING;
            r_strength    <= '0;
            r_rsq         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.op == OP_LIFE) begin
                r_phase    <= n_phase;
                r_strength <= n_strength;
            end
            if (i_cmd.op == OP_SAVE_RSQ) begin
                r_rsq <= r_prod[RSQ_W-1:0];
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Any register write starts a new thermal.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BASE_X:        r_base_x      <= i_cfg_data;
                    REG_BASE_Y:        r_base_y      <= i_cfg_data;
                    REG_BASE_Z:        r_base_z      <= i_cfg_data;
                    REG_CYL_HEIGHT:    r_cyl_height  <= i_cfg_data[VAL_W-1:0];
                    REG_FULL_RADIUS:   r_full_radius <= i_cfg_data[VAL_W-1:0];
                    REG_PEAK_STRENGTH: r_peak        <= i_cfg_data[VAL_W-1:0];
                    REG_RAMP_RATE:     r_ramp        <= i_cfg_data[VAL_W-1:0];
                    REG_SHRINK_RATE:   r_shrink      <= i_cfg_data[VAL_W-1:0];
                    default:           r_shrink      <= r_shrink;
                endcase
                r_phase    <= (n_ramp == '0) ? PH_ON : PH_GROWING;
                r_strength <= (n_ramp == '0) ? n_peak : '0;
                r_rsq      <= '0;
            end
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_p[PROD_W-1:0];
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_item     <= i_item;
                r_vel      <= '0;
                r_finished <= 1'b0;
            end
            OP_MUL_SHR:  r_inc      <= r_prod[RSQ_W-1:VAL_W];
            OP_LIFE:     r_finished <= n_life_done;
            OP_RAD_PICK: r_r        <= w_rad_zero ? '0 : '1;
            OP_RAD_TAKE: r_r        <= w_div_quot;
            OP_DIFF: begin
                r_dx  <= w_dx_mag;
                r_dy  <= w_dy_mag;
                r_zin <= w_zin;
            end
            OP_MUL_DY:   r_acc      <= r_prod;
            OP_SUM:      r_acc      <= r_acc + r_prod;
            OP_VEL_TAKE: r_vel      <= w_div_quot;
            OP_EMIT: begin
                r_out.velocity_z     <= r_vel;
                r_out.strength_now   <= r_strength;
                r_out.radius_squared <= r_rsq;
                r_out.phase          <= r_phase;
                r_out.finished       <= r_finished;
            end
            default: begin
                r_inc <= r_inc;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;
    assign o_status.is_query = (r_item.cmd == CMD_QUERY);
    assign o_status.finished = r_finished;
    assign o_status.rad_zero = w_rad_zero;
    assign o_status.rad_sat  = w_rad_sat;
    assign o_status.in_cyl   = r_zin && (r_acc < PROD_W'(r_rsq));
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    `TLU_ASSERT_SAME(a_emit_free, i_cmd.op == OP_EMIT, !r_out_valid || i_out_ready,
        "result register overwritten before it was taken")
    `TLU_ASSERT_SAME(a_strength_cap, 1'b1, r_strength <= r_peak,
        "strength above peak strength")
    `TLU_ASSERT_SAME(a_off_empty, r_phase == PH_OFF, r_strength == '0,
        "thermal off with non-zero strength")

endmodule

/* hdl/thermal_lifecycle_and_updraft.sv */
// Top level of the thermal updraft block: controller, datapath and channels.
//
// Usage. One input channel (i_item) takes tick and query transactions; one
// output channel (o_result) returns exactly one result transaction for each,
// in order. A tick (cmd 0) advances the life cycle by step_time and, unless
// it finishes the thermal, updates the radius squared; a query (cmd 1)
// returns the upward velocity at a point. Registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce; every write restarts
// the thermal. A non-finishing tick whose radius is neither zero nor saturated
// and a query inside the cylinder each run a division on the 16-step serial
// divider shared by the radius and velocity paths. One item is processed at a
// time; the next transaction is accepted at the earliest in the cycle after
// the result has been written to the output register.
// Reset (synchronous, active low) loads the default registers and a growing
// thermal of zero strength; i_item.ready rises in the cycle after reset ends.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and processed, and waits before its own result is written.
module thermal_lifecycle_and_updraft #(
    parameter int FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tlu_stream_if.sink                      i_item,
    tlu_stream_if.source                    o_result
);
    import tlu_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencing of each transaction.
    tlu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, state and result register.
    tlu_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out       (o_result.data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
